// ===== rtl/sts_pkg.sv =====
// Shared types, constants and lookup functions for the sphere triangle subdivider.
package sts_pkg;

  localparam int COORD_W        = 16;
  localparam int SUM_W          = COORD_W + 1;
  localparam int LEN_W          = 2 * SUM_W + 2;
  localparam int ROOT_W         = SUM_W;
  localparam int SQRT_STEPS     = LEN_W / 2;
  localparam int OUT_INDEX_W    = 32;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int INDEX_BITS_DEF = 32;
  localparam int VERTS_PER_TRI  = 3;
  localparam int VERTS_PER_ITEM = 12;

  // point slots: corners then midpoints
  localparam logic [2:0] PT_A   = 3'd0;
  localparam logic [2:0] PT_B   = 3'd1;
  localparam logic [2:0] PT_C   = 3'd2;
  localparam logic [2:0] PT_M01 = 3'd3;
  localparam logic [2:0] PT_M12 = 3'd4;
  localparam logic [2:0] PT_M02 = 3'd5;

  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_AC = 2'd2;
  localparam logic [1:0] AXIS_Z  = 2'd2;
  localparam logic [1:0] TRI_LAST = 2'd3;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic       sq_first;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       emit;
    logic [1:0] edge_sel;
    logic [1:0] axis;
    logic [1:0] tri_idx;
  } sts_cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_stat_t;

  function automatic logic [1:0] edge_first(input logic [1:0] e);
    edge_first = (e == EDGE_BC) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] edge_second(input logic [1:0] e);
    edge_second = (e == EDGE_AB) ? 2'd1 : 2'd2;
  endfunction

  // corner slots of each output triangle, {p, q, r}
  function automatic logic [8:0] tri_corners(input logic [1:0] t);
    unique case (t)
      2'd0:    tri_corners = {PT_A,   PT_M01, PT_M02};
      2'd1:    tri_corners = {PT_M01, PT_B,   PT_M12};
      2'd2:    tri_corners = {PT_M01, PT_M12, PT_M02};
      default: tri_corners = {PT_M02, PT_M12, PT_C};
    endcase
  endfunction

endpackage

// ===== rtl/sts_ctrl.sv =====
// Sequencer for the subdivider: squares, root, divisions, then four emits.
module sts_ctrl
  import sts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sts_stat_t stat,
  output sts_cmd_t  cmd
);

  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int CW = $clog2(DIV_STEPS + SQRT_STEPS + 2);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_ROOT = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [1:0]    edge_sel, edge_sel_next;
  logic [1:0]    axis, axis_next;
  logic [1:0]    tri_idx, tri_idx_next;
  logic [CW-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    edge_sel_next = edge_sel;
    axis_next     = axis;
    tri_idx_next  = tri_idx;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.edge_sel  = edge_sel;
    cmd.axis      = axis;
    cmd.tri_idx   = tri_idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          edge_sel_next = EDGE_AB;
          axis_next     = '0;
          state_next    = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_en    = 1'b1;
        cmd.sq_first = (axis == '0);
        if (axis == AXIS_Z) begin
          axis_next  = '0;
          cnt_next   = '0;
          state_next = S_ROOT;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_ROOT: begin
        cmd.root_init = (cnt == '0);
        cmd.root_step = (cnt != '0);
        if (cnt == CW'(SQRT_STEPS)) begin
          cnt_next   = '0;
          state_next = S_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_init  = (cnt == '0);
        cmd.div_step  = (cnt != '0) && (cnt <= CW'(DIV_STEPS));
        cmd.div_store = (cnt == CW'(DIV_STEPS + 1));
        if (cnt == CW'(DIV_STEPS + 1)) begin
          cnt_next = '0;
          if (axis == AXIS_Z) begin
            axis_next = '0;
            if (edge_sel == EDGE_AC) begin
              tri_idx_next = '0;
              state_next   = S_EMIT;
            end else begin
              edge_sel_next = edge_sel + 2'd1;
              state_next    = S_SQ;
            end
          end else begin
            axis_next = axis + 2'd1;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          tri_idx_next = tri_idx + 2'd1;
          if (tri_idx == TRI_LAST) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      edge_sel <= '0;
      axis     <= '0;
      tri_idx  <= '0;
      cnt      <= '0;
    end else begin
      state    <= state_next;
      edge_sel <= edge_sel_next;
      axis     <= axis_next;
      tri_idx  <= tri_idx_next;
      cnt      <= cnt_next;
    end
  end

endmodule

// ===== rtl/sts_dp.sv =====
// Datapath: corner store, squared length, bitwise root, restoring divide, output regs.
module sts_dp
  import sts_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sts_cmd_t                  cmd,
  output sts_stat_t                 stat,
  input  logic                      start_pass,
  input  logic signed [COORD_W-1:0] a_x, a_y, a_z,
  input  logic signed [COORD_W-1:0] b_x, b_y, b_z,
  input  logic signed [COORD_W-1:0] c_x, c_y, c_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] p_x, p_y, p_z,
  output logic signed [COORD_W-1:0] q_x, q_y, q_z,
  output logic signed [COORD_W-1:0] r_x, r_y, r_z,
  output logic [OUT_INDEX_W-1:0]    first_index,
  output logic                      last
);

  localparam int QB = FRAC_BITS + 1;
  localparam int NW = SUM_W + FRAC_BITS + 2;
  localparam int DW = NW - QB;

  logic signed [COORD_W-1:0] vtx [3][3];
  logic signed [COORD_W-1:0] mid [3][3];
  logic signed [COORD_W-1:0] pts [6][3];

  logic signed [COORD_W-1:0] cu, cw;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]          mag;
  logic [2*SUM_W-1:0]        sq;
  logic [LEN_W-1:0]          len2;

  logic [LEN_W-1:0] sn, sres, sbit;
  logic [LEN_W:0]   strial;
  logic             sge;
  logic [ROOT_W-1:0] root;

  logic [NW-1:0] numer;
  logic [DW-1:0] dvsr, rem;
  logic [QB-1:0] nlo, quo, qsat;
  logic [DW:0]   dtrial, ddiff;
  logic          dge;
  logic signed [63:0] qsigned;

  logic [INDEX_BITS-1:0] base, next_idx, idx_start;
  logic [8:0]            corners;

  always_comb begin
    cu  = vtx[edge_first(cmd.edge_sel)][cmd.axis];
    cw  = vtx[edge_second(cmd.edge_sel)][cmd.axis];
    sum = {cu[COORD_W-1], cu} + {cw[COORD_W-1], cw};
    mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    sq  = mag * mag;
  end

  always_comb begin
    strial = {1'b0, sres} + {1'b0, sbit};
    sge    = {1'b0, sn} >= strial;
    root   = sres[ROOT_W-1:0];
  end

  always_comb begin
    numer   = {mag, {QB{1'b0}}} + NW'(root);
    dvsr    = {root, 1'b0};
    dtrial  = {rem, nlo[QB-1]};
    dge     = dtrial >= {1'b0, dvsr};
    ddiff   = dtrial - {1'b0, dvsr};
    qsat    = (quo > (QB'(1) << FRAC_BITS)) ? (QB'(1) << FRAC_BITS) : quo;
    qsigned = sum[SUM_W-1] ? -$signed(64'(qsat)) : $signed(64'(qsat));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pts[0][k] = vtx[0][k];
      pts[1][k] = vtx[1][k];
      pts[2][k] = vtx[2][k];
      pts[3][k] = mid[0][k];
      pts[4][k] = mid[1][k];
      pts[5][k] = mid[2][k];
    end
    corners = tri_corners(cmd.tri_idx);
  end

  assign idx_start = start_pass ? '0 : next_idx;
  assign stat.out_free = !out_valid || out_ready;

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vtx[0][0] <= a_x; vtx[0][1] <= a_y; vtx[0][2] <= a_z;
      vtx[1][0] <= b_x; vtx[1][1] <= b_y; vtx[1][2] <= b_z;
      vtx[2][0] <= c_x; vtx[2][1] <= c_y; vtx[2][2] <= c_z;
      base      <= idx_start;
    end
    if (cmd.sq_en) len2 <= cmd.sq_first ? LEN_W'(sq) : len2 + LEN_W'(sq);
    if (cmd.root_init) begin
      sn   <= len2;
      sres <= '0;
      sbit <= LEN_W'(1) << (LEN_W - 2);
    end else if (cmd.root_step) begin
      if (sge) begin
        sn   <= sn - strial[LEN_W-1:0];
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.div_init) begin
      rem <= numer[NW-1:QB];
      nlo <= numer[QB-1:0];
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= dge ? ddiff[DW-1:0] : dtrial[DW-1:0];
      nlo <= nlo << 1;
      quo <= {quo[QB-2:0], dge};
    end
    if (cmd.div_store) begin
      mid[cmd.edge_sel][cmd.axis] <= (root == '0) ? '0 : qsigned[COORD_W-1:0];
    end
    if (cmd.emit) begin
      p_x <= pts[corners[8:6]][0]; p_y <= pts[corners[8:6]][1]; p_z <= pts[corners[8:6]][2];
      q_x <= pts[corners[5:3]][0]; q_y <= pts[corners[5:3]][1]; q_z <= pts[corners[5:3]][2];
      r_x <= pts[corners[2:0]][0]; r_y <= pts[corners[2:0]][1]; r_z <= pts[corners[2:0]][2];
      first_index <= OUT_INDEX_W'(base + INDEX_BITS'(VERTS_PER_TRI) * INDEX_BITS'(cmd.tri_idx));
      last        <= (cmd.tri_idx == TRI_LAST);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      next_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) next_idx <= idx_start + INDEX_BITS'(VERTS_PER_ITEM);
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/sphere_triangle_subdivider.sv =====
// A request is accepted, computed, then its four triangles are emitted; no new request is
//   taken until the fourth triangle has been emitted. The computation uses the shared
//   bitwise square root (18 steps) and the restoring divider (FRAC_BITS+1 steps).
// Results go out one triangle per cycle while the consumer takes them.
// Reset: synchronous, active high; clears the sequencer, output valid and vertex index.
module sphere_triangle_subdivider
  import sts_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      start_pass,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] p_x,
  output logic signed [COORD_W-1:0] p_y,
  output logic signed [COORD_W-1:0] p_z,
  output logic signed [COORD_W-1:0] q_x,
  output logic signed [COORD_W-1:0] q_y,
  output logic signed [COORD_W-1:0] q_z,
  output logic signed [COORD_W-1:0] r_x,
  output logic signed [COORD_W-1:0] r_y,
  output logic signed [COORD_W-1:0] r_z,
  output logic [OUT_INDEX_W-1:0]    first_index,
  output logic                      last
);

  // sequencer commands and datapath status
  sts_cmd_t  cmd;
  sts_stat_t stat;

  // Sequencer: per edge three squares, root, three divides; then the four triangles.
  sts_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds corners, midpoints, arithmetic units and the output register.
  sts_dp #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .start_pass  (start_pass),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .p_x(p_x), .p_y(p_y), .p_z(p_z),
    .q_x(q_x), .q_y(q_y), .q_z(q_z),
    .r_x(r_x), .r_y(r_y), .r_z(r_z),
    .first_index (first_index),
    .last        (last)
  );

  // one request at a time: the block goes busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready after request accepted");

  // returning to idle only once the fourth triangle is presented
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> out_valid && last)
    else $error("idle without last triangle pending");

  // the emit command never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwritten");

endmodule
